@@ hw/rtl/u8d_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_pkg: shared types and constants of the UTF-8 stream decoder
// Result status codes, lead byte classes and field widths.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CpW     = 21;
  localparam int unsigned CpPadW  = 24;
  localparam int unsigned StatusW = 2;

  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [CpW-1:0]     cp_t;
  typedef logic [StatusW-1:0] status_t;

  localparam status_t ST_CHAR = 2'd0;
  localparam status_t ST_ERR  = 2'd1;
  localparam status_t ST_END  = 2'd2;

  // lead byte class of the sequence in progress
  typedef enum logic [2:0] {
    LC_NONE     = 3'd0,
    LC_TWO      = 3'd1,
    LC_THREE    = 3'd2,
    LC_THREE_E0 = 3'd3,
    LC_FOUR     = 3'd4,
    LC_FOUR_F0  = 3'd5
  } lead_class_t;

  localparam byte_t LEAD_TWO_MIN   = 8'hC2;
  localparam byte_t LEAD_THREE_MIN = 8'hE0;
  localparam byte_t LEAD_FOUR_MIN  = 8'hF0;
  localparam byte_t LEAD_BAD_MIN   = 8'hF8;
  localparam byte_t E0_SECOND_MIN  = 8'hA0;
  localparam byte_t F0_SECOND_MIN  = 8'h90;

endpackage

`default_nettype wire

@@ hw/rtl/utf8_stream_decoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder: byte-serial UTF-8 decoder
// Rebuilds code points of one to four bytes from a NUL-terminated string.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the input is ready, and a result, when the
// byte causes one, sits in the output register on the following cycle, past
// the single decode stage between the sequence state and the output
// register. The input is ready whenever the output register is empty or
// being taken in the same cycle. Results are a decoded character, an
// invalid-sequence flag, or an end-of-string marker for a NUL outside a
// sequence. After an error the rest of the string up to its NUL is dropped
// silently.
module utf8_stream_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [20:0] code_point, [23:21] zero
  output logic [1:0]       m_axis_tuser    // [1:0] status
);

  logic                 [1:0] pending, pending_next;
  u8d_pkg::cp_t               partial, partial_next;
  u8d_pkg::lead_class_t       lead, lead_next;
  logic                       second, second_next;
  logic                       halted, halted_next;

  logic                       emit;
  u8d_pkg::cp_t               emit_cp;
  u8d_pkg::status_t           emit_st;

  logic                       accept;
  u8d_pkg::cp_t               out_cp;
  u8d_pkg::status_t           out_st;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    logic [7:0] b;
    logic [5:0] payload;
    logic       bad_cont;
    b        = s_axis_tdata;
    payload  = b[5:0];
    bad_cont = (b[7:6] != 2'b10);

    pending_next = pending;
    partial_next = partial;
    lead_next    = lead;
    second_next  = second;
    halted_next  = halted;
    emit         = 1'b0;
    emit_cp      = '0;
    emit_st      = u8d_pkg::ST_CHAR;

    if (halted) begin
      // dead string: drop bytes until the terminating NUL
      if (b == 8'h00) begin
        halted_next = 1'b0;
        pending_next = 2'd0;
        partial_next = '0;
        lead_next    = u8d_pkg::LC_NONE;
        second_next  = 1'b0;
      end
    end else if (pending == 2'd0) begin
      if (b == 8'h00) begin
        emit    = 1'b1;
        emit_st = u8d_pkg::ST_END;
      end else if (!b[7]) begin
        emit    = 1'b1;
        emit_cp = u8d_pkg::cp_t'(b);
      end else if (b < u8d_pkg::LEAD_TWO_MIN || b >= u8d_pkg::LEAD_BAD_MIN) begin
        emit        = 1'b1;
        emit_st     = u8d_pkg::ST_ERR;
        halted_next = 1'b1;
      end else if (b < u8d_pkg::LEAD_THREE_MIN) begin
        pending_next = 2'd1;
        partial_next = u8d_pkg::cp_t'(b[4:0]);
        lead_next    = u8d_pkg::LC_TWO;
        second_next  = 1'b1;
      end else if (b < u8d_pkg::LEAD_FOUR_MIN) begin
        pending_next = 2'd2;
        partial_next = u8d_pkg::cp_t'(b[3:0]);
        lead_next    = (b == u8d_pkg::LEAD_THREE_MIN) ? u8d_pkg::LC_THREE_E0
                                                      : u8d_pkg::LC_THREE;
        second_next  = 1'b1;
      end else begin
        pending_next = 2'd3;
        partial_next = u8d_pkg::cp_t'(b[2:0]);
        lead_next    = (b == u8d_pkg::LEAD_FOUR_MIN) ? u8d_pkg::LC_FOUR_F0
                                                     : u8d_pkg::LC_FOUR;
        second_next  = 1'b1;
      end
    end else if (bad_cont
        || (second && lead == u8d_pkg::LC_THREE_E0 && b < u8d_pkg::E0_SECOND_MIN)
        || (second && lead == u8d_pkg::LC_FOUR_F0 && b < u8d_pkg::F0_SECOND_MIN)) begin
      // a NUL here ends the string too, so it leaves the decoder live
      emit         = 1'b1;
      emit_st      = u8d_pkg::ST_ERR;
      halted_next  = (b != 8'h00);
      pending_next = 2'd0;
      partial_next = '0;
      lead_next    = u8d_pkg::LC_NONE;
      second_next  = 1'b0;
    end else begin
      second_next  = 1'b0;
      pending_next = pending - 2'd1;
      if (pending == 2'd1) begin
        emit         = 1'b1;
        emit_cp      = {partial[u8d_pkg::CpW-7:0], payload};
        partial_next = '0;
        lead_next    = u8d_pkg::LC_NONE;
      end else begin
        partial_next = {partial[u8d_pkg::CpW-7:0], payload};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending       <= 2'd0;
      partial       <= '0;
      lead          <= u8d_pkg::LC_NONE;
      second        <= 1'b0;
      halted        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        pending <= pending_next;
        partial <= partial_next;
        lead    <= lead_next;
        second  <= second_next;
        halted  <= halted_next;
      end
      if (accept && emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // hold the payload until the request is taken
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_cp <= emit_cp;
      out_st <= emit_st;
    end
  end

  assign m_axis_tdata = {{(u8d_pkg::CpPadW - u8d_pkg::CpW){1'b0}}, out_cp};
  assign m_axis_tuser = out_st;

endmodule

`default_nettype wire

@@ hw/rtl/u8d_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_checker: port-level checks of the UTF-8 stream decoder
// Watches the stream ports and flags results that cannot be right.
// ----------------------------------------------------------------------------
module u8d_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // a stalled result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("u8d: stalled result changed");

  // error and end results carry no code point
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != u8d_pkg::ST_CHAR) |-> (m_axis_tdata == '0))
    else $error("u8d: non-character result with nonzero code point");

  // the padding above the code point stays clear
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[23:21] == 3'b000))
    else $error("u8d: padding bits set");

  // an empty output register never blocks the input
  assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("u8d: input stalled with output empty");

  // no result shows in the first cycle after reset
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("u8d: result shown straight after reset");

endmodule

bind utf8_stream_decoder u8d_checker u_u8d_checker (.*);

`default_nettype wire
